// ===== rtl/core/inc_pkg.sv =====
// Package: widths, constants and shared types for the inverse normal CDF unit.
`default_nettype none
package inc_pkg;

    localparam int PROB_BITS     = 32;
    localparam int OUT_FRAC_BITS = 28;
    localparam int OUT_W         = OUT_FRAC_BITS + 4;

    // internal fixed point: Q.24 for t and the rational correction
    localparam int FB = 24;

    // log2 stage: mantissa Q1.31, fraction Q0.32, one squaring per stage
    localparam int MANT_W    = 32;
    localparam int LOG_STEPS = 32;
    localparam int KW        = $clog2(PROB_BITS);
    localparam int LINT_W    = $clog2(PROB_BITS + 1);
    localparam int L_W       = LINT_W + 32;

    // -2 ln q and its square root
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int HI_W   = LINT_W + 32;
    localparam int SUM_W  = L_W + 1;
    localparam int S_W    = SUM_W + 1;
    localparam int ROOT_W = (S_W - 8 + FB + 1) / 2;
    localparam int RAD_W  = 2 * ROOT_W;

    // rational correction
    localparam int DEN_W = 30;
    localparam int NUM_W = 28;
    localparam int PW    = DEN_W + ROOT_W;

    localparam logic [DEN_W-1:0] K_C0   = DEN_W'(42203372);
    localparam logic [DEN_W-1:0] K_C1   = DEN_W'(13469638);
    localparam logic [DEN_W-1:0] K_C2   = DEN_W'(173275);
    localparam logic [DEN_W-1:0] K_D1   = DEN_W'(24038194);
    localparam logic [DEN_W-1:0] K_D2   = DEN_W'(3175407);
    localparam logic [DEN_W-1:0] K_D3   = DEN_W'(21945);
    localparam logic [DEN_W-1:0] ONE_FB = DEN_W'(1) << FB;

    // output rescale and saturation
    localparam int SH    = OUT_FRAC_BITS - FB;
    localparam int SH_L  = (SH > 0) ? SH : 0;
    localparam int SH_R  = (SH < 0) ? -SH : 0;
    localparam int MAG_W = (ROOT_W + SH_L > OUT_W) ? ROOT_W + SH_L : OUT_W;

    localparam logic [OUT_W-1:0] Q_NEG_ONE = OUT_W'(0) - (OUT_W'(1) << OUT_FRAC_BITS);

    // flags that ride along with each item
    typedef struct packed {
        logic lower;
        logic invalid;
    } side_t;

endpackage
`default_nettype wire

// ===== rtl/core/inc_log2.sv =====
// Folding of p to q, normalization and the bit-serial -log2(q) pipeline.
`default_nettype none
module inc_log2
    import inc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [PROB_BITS-1:0] prob,
    output logic                 out_valid,
    output logic [L_W-1:0]       lval,
    output side_t                out_side
);

    logic [LOG_STEPS:0] v_reg;
    logic [MANT_W-1:0]  m_reg [LOG_STEPS+1];
    logic [31:0]        f_reg [LOG_STEPS+1];
    logic [KW-1:0]      k_reg [LOG_STEPS+1];
    side_t              s_reg [LOG_STEPS+1];

    logic                       lower;
    logic [PROB_BITS-1:0]       q;
    logic [KW-1:0]              k;
    logic [PROB_BITS+30:0]      qx;
    side_t                      s0;

    logic                 lv_reg;
    logic [L_W-1:0]       l_reg;
    side_t                ls_reg;
    logic [LINT_W-1:0]    lint;

    // fold to the lower tail and find the leading one
    always_comb
    begin
        lower = prob < (PROB_BITS'(1) << (PROB_BITS - 1));
        q     = lower ? prob : (~prob) + PROB_BITS'(1);
        k     = '0;
        for (int i = 0; i < PROB_BITS; i++)
        begin
            if (q[i])
            begin
                k = KW'(i);
            end
        end
        qx         = {q, 31'b0} >> k;
        s0.lower   = lower;
        s0.invalid = (prob == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= qx[MANT_W-1:0];
            f_reg[0] <= '0;
            k_reg[0] <= k;
            s_reg[0] <= s0;
        end
    end

    // one squaring per stage yields one fraction bit
    for (genvar g = 1; g <= LOG_STEPS; g++)
    begin : g_step
        logic [2*MANT_W-1:0] prod;
        logic [MANT_W:0]     sq;

        assign prod = m_reg[g-1] * m_reg[g-1];
        assign sq   = prod[2*MANT_W-1:MANT_W-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[g] <= sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
                f_reg[g] <= {f_reg[g-1][30:0], sq[MANT_W]};
                k_reg[g] <= k_reg[g-1];
                s_reg[g] <= s_reg[g-1];
            end
        end
    end

    assign lint = LINT_W'(PROB_BITS) - LINT_W'(k_reg[LOG_STEPS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_reg <= 1'b0;
        end
        else if (en)
        begin
            lv_reg <= v_reg[LOG_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg  <= {lint, 32'b0} - L_W'(f_reg[LOG_STEPS]);
            ls_reg <= s_reg[LOG_STEPS];
        end
    end

    assign out_valid = lv_reg;
    assign lval      = l_reg;
    assign out_side  = ls_reg;

endmodule
`default_nettype wire

// ===== rtl/core/inc_sqrt.sv =====
// Scaling by 2 ln 2 and the one-bit-per-stage square root giving t.
`default_nettype none
module inc_sqrt
    import inc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [L_W-1:0]    lval,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] tval,
    output side_t             out_side
);

    logic            av_reg;
    logic [HI_W-1:0] hi_reg;
    logic [63:0]     lo_reg;
    side_t           as_reg;

    logic [SUM_W-1:0] sum;
    logic [S_W-1:0]   s_val;

    logic [ROOT_W:0]    v_reg;
    logic [RAD_W-1:0]   rad_reg  [ROOT_W+1];
    logic [ROOT_W:0]    rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]  root_reg [ROOT_W+1];
    side_t              s_reg    [ROOT_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            av_reg <= 1'b0;
        end
        else if (en)
        begin
            av_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg <= HI_W'(lval[L_W-1:32]) * HI_W'(LN2_Q32);
            lo_reg <= 64'(lval[31:0]) * 64'(LN2_Q32);
            as_reg <= in_side;
        end
    end

    assign sum   = SUM_W'(hi_reg) + SUM_W'(lo_reg[63:32]);
    assign s_val = {sum, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= av_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= RAD_W'(s_val[S_W-1:8]) << FB;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            s_reg[0]    <= as_reg;
        end
    end

    // restoring square root, two radicand bits per stage
    for (genvar g = 1; g <= ROOT_W; g++)
    begin : g_root
        logic [ROOT_W+2:0] rem2;
        logic [ROOT_W+2:0] trial;
        logic              fit;

        assign rem2  = {rem_reg[g-1], rad_reg[g-1][RAD_W-1 -: 2]};
        assign trial = (ROOT_W+3)'({root_reg[g-1], 2'b01});
        assign fit   = rem2 >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[g]  <= rad_reg[g-1] << 2;
                rem_reg[g]  <= fit ? (ROOT_W+1)'(rem2 - trial) : rem2[ROOT_W:0];
                root_reg[g] <= {root_reg[g-1][ROOT_W-2:0], fit};
                s_reg[g]    <= s_reg[g-1];
            end
        end
    end

    assign out_valid = v_reg[ROOT_W];
    assign tval      = root_reg[ROOT_W];
    assign out_side  = s_reg[ROOT_W];

endmodule
`default_nettype wire

// ===== rtl/core/inc_ratio.sv =====
// Horner evaluation of the correction polynomials and the quotient pipeline.
`default_nettype none
module inc_ratio
    import inc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] tval,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_t,
    output logic [NUM_W-1:0]  ratio,
    output side_t             out_side
);

    logic [2:0]        pv_reg;
    logic [ROOT_W-1:0] pt_reg [3];
    side_t             ps_reg [3];
    logic [PW-1:0]     n1_reg, d1_reg, n2_reg, d2_reg, d3_reg;
    logic [NUM_W-1:0]  num_reg;

    logic [DEN_W-1:0] a_n2, a_d2, a_d3, den;

    logic [NUM_W:0]    v_reg;
    logic [DEN_W-1:0]  rem_reg [NUM_W+1];
    logic [DEN_W-1:0]  den_reg [NUM_W+1];
    logic [NUM_W-1:0]  dlo_reg [NUM_W+1];
    logic [NUM_W-1:0]  quo_reg [NUM_W+1];
    logic [ROOT_W-1:0] t_reg   [NUM_W+1];
    side_t             s_reg   [NUM_W+1];

    assign a_n2 = DEN_W'(n1_reg >> FB) + K_C1;
    assign a_d2 = DEN_W'(d1_reg >> FB) + K_D2;
    assign a_d3 = DEN_W'(d2_reg >> FB) + K_D1;
    assign den  = DEN_W'(d3_reg >> FB) + ONE_FB;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
        end
        else if (en)
        begin
            pv_reg <= {pv_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg[0] <= tval;
            ps_reg[0] <= in_side;
            for (int i = 1; i < 3; i++)
            begin
                pt_reg[i] <= pt_reg[i-1];
                ps_reg[i] <= ps_reg[i-1];
            end
            n1_reg  <= PW'(K_C2) * PW'(tval);
            d1_reg  <= PW'(K_D3) * PW'(tval);
            n2_reg  <= PW'(a_n2) * PW'(pt_reg[0]);
            d2_reg  <= PW'(a_d2) * PW'(pt_reg[0]);
            num_reg <= NUM_W'(n2_reg >> FB) + NUM_W'(K_C0);
            d3_reg  <= PW'(a_d3) * PW'(pt_reg[1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= pv_reg[2];
        end
    end

    // dividend is num * 2^FB; its upper part is already below den
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DEN_W'(num_reg >> (NUM_W - FB));
            den_reg[0] <= den;
            dlo_reg[0] <= NUM_W'(num_reg << FB);
            quo_reg[0] <= '0;
            t_reg[0]   <= pt_reg[2];
            s_reg[0]   <= ps_reg[2];
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar g = 1; g <= NUM_W; g++)
    begin : g_div
        logic [DEN_W:0] r2;
        logic           fit;

        assign r2  = {rem_reg[g-1], dlo_reg[g-1][NUM_W-1]};
        assign fit = r2 >= {1'b0, den_reg[g-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= fit ? DEN_W'(r2 - {1'b0, den_reg[g-1]}) : r2[DEN_W-1:0];
                den_reg[g] <= den_reg[g-1];
                dlo_reg[g] <= dlo_reg[g-1] << 1;
                quo_reg[g] <= {quo_reg[g-1][NUM_W-2:0], fit};
                t_reg[g]   <= t_reg[g-1];
                s_reg[g]   <= s_reg[g-1];
            end
        end
    end

    assign out_valid = v_reg[NUM_W];
    assign out_t     = t_reg[NUM_W];
    assign ratio     = quo_reg[NUM_W];
    assign out_side  = s_reg[NUM_W];

endmodule
`default_nettype wire

// ===== rtl/core/inc_out.sv =====
// Sign, rescale and saturation of the result, and the two-beat output buffer.
`default_nettype none
module inc_out
    import inc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] tval,
    input  logic [NUM_W-1:0]  ratio,
    input  side_t             in_side,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [OUT_W-1:0]  quantile,
    output logic              invalid
);

    logic signed [ROOT_W:0] r;
    logic                   neg;
    logic [ROOT_W-1:0]      mag;
    logic [MAG_W-1:0]       mag_s, lim;
    logic [OUT_W-1:0]       res;

    logic [OUT_W-1:0] q_buf_reg [2];
    logic             i_buf_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg, cnt_next;
    logic             push, pop;

    always_comb
    begin
        r     = $signed({1'b0, tval}) - $signed((ROOT_W+1)'(ratio));
        mag   = r[ROOT_W] ? ROOT_W'(-r) : r[ROOT_W-1:0];
        neg   = r[ROOT_W] ^ in_side.lower;
        mag_s = (MAG_W'(mag) << SH_L) >> SH_R;
        lim   = MAG_W'(1) << (OUT_W - 1);
        if (!neg && mag_s > lim - MAG_W'(1))
        begin
            mag_s = lim - MAG_W'(1);
        end
        if (neg && mag_s > lim)
        begin
            mag_s = lim;
        end
        if (in_side.invalid)
        begin
            res = Q_NEG_ONE;
        end
        else
        begin
            res = neg ? OUT_W'(0) - mag_s[OUT_W-1:0] : mag_s[OUT_W-1:0];
        end
    end

    assign room      = (cnt_reg != 2'd2);
    assign push      = in_valid && room;
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_buf_reg[wr_ptr_reg] <= res;
            i_buf_reg[wr_ptr_reg] <= in_side.invalid;
        end
    end

    assign quantile = q_buf_reg[rd_ptr_reg];
    assign invalid  = i_buf_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// ===== rtl/core/inverse_normal_cdf_unit.sv =====
// Top level: inverse standard normal CDF, probability in, quantile out.
// Path from an accepted input beat to its output beat: 34 log2 stages,
//   30 scaling and square-root stages, 32 polynomial and quotient stages,
//   1 output buffer stage.
// Throughput: one beat per clock; the whole pipeline advances together and
//   stalls only when the two-beat output buffer is full.
// Reset: rst_n clears all valid bits and the output buffer; no state is kept.
`default_nettype none
module inverse_normal_cdf_unit
    import inc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PROB_BITS-1:0] prob,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [OUT_W-1:0] quantile,
    output logic                 invalid
);

    // pipeline enable: every stage moves while the output buffer has room
    logic en;

    logic              log_valid;
    logic [L_W-1:0]    lval;
    side_t             log_side;

    logic              sq_valid;
    logic [ROOT_W-1:0] tval;
    side_t             sq_side;

    logic              rt_valid;
    logic [ROOT_W-1:0] rt_t;
    logic [NUM_W-1:0]  ratio;
    side_t             rt_side;

    logic              room;
    logic [OUT_W-1:0]  q_out;

    assign en       = room;
    assign in_ready = en;

    // q = min(p, 1-p), mantissa, then -log2(q) one bit per squaring stage
    inc_log2 u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .prob      (prob),
        .out_valid (log_valid),
        .lval      (lval),
        .out_side  (log_side)
    );

    // -2 ln q, then t = sqrt(-2 ln q) in Q.24
    inc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (log_valid),
        .lval      (lval),
        .in_side   (log_side),
        .out_valid (sq_valid),
        .tval      (tval),
        .out_side  (sq_side)
    );

    // numerator and denominator by Horner, then their quotient
    inc_ratio u_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .tval      (tval),
        .in_side   (sq_side),
        .out_valid (rt_valid),
        .out_t     (rt_t),
        .ratio     (ratio),
        .out_side  (rt_side)
    );

    // t - ratio, sign from the tail, rescale, saturate, buffer
    inc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rt_valid),
        .tval      (rt_t),
        .ratio     (ratio),
        .in_side   (rt_side),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quantile  (q_out),
        .invalid   (invalid)
    );

    assign quantile = $signed(q_out);

    // a zero probability always reports minus one
    a_invalid_value: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> q_out == Q_NEG_ONE
    ) else $error("invalid beat without -1.0 quantile");

    // input is held off only while finished results are waiting
    a_stall_reason: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid
    ) else $error("input stalled with empty output buffer");

    // a full buffer that is not drained stays full
    a_full_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready && !out_ready |=> !in_ready
    ) else $error("output buffer lost a beat");

endmodule
`default_nettype wire

// ===== test/inverse_normal_cdf_unit_test.sv =====
// Testbench for the inverse normal CDF unit: directed table, then random bursts.
`timescale 1ns / 100ps
`default_nettype none
module inverse_normal_cdf_unit_test;
    import inc_pkg::*;

    // Fixed-point constants of the quantile computation (ln 2 in Q0.32, coefficients in Q.24)
    localparam longint unsigned LN2_FIX = 64'd2977044472;
    localparam longint unsigned C0 = 64'd42203372;
    localparam longint unsigned C1 = 64'd13469638;
    localparam longint unsigned C2 = 64'd173275;
    localparam longint unsigned D1 = 64'd24038194;
    localparam longint unsigned D2 = 64'd3175407;
    localparam longint unsigned D3 = 64'd21945;
    localparam int PIPE_DEPTH = 97;
    localparam int N_RANDOM   = 1900;

    typedef struct packed {
        logic [OUT_W-1:0] quantile;
        logic             invalid;
    } quant_t;

    // One directed row: probability, whether the expectation is typed in, and the value
    typedef struct {
        logic [PROB_BITS-1:0] prob;
        bit                   fixed;
        quant_t               want;
    } row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [PROB_BITS-1:0]    prob;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [OUT_W-1:0] quantile;
    logic                    invalid;

    quant_t pending_q[$];
    int     n_errors;
    bit     stim_done;
    bit     long_stall;

    inverse_normal_cdf_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .prob      (prob),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quantile  (quantile),
        .invalid   (invalid)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // floor(sqrt(v)), bit-by-bit
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // -log2(q / 2^PROB_BITS) in Q.32, via repeated squaring of the mantissa
    function automatic longint unsigned minus_log2(longint unsigned q);
        int              k;
        longint unsigned m;
        longint unsigned f;
        k = PROB_BITS - 1;
        f = 0;
        while (k > 0 && q[k] == 1'b0)
            k--;
        if (k <= 31)
            m = q << (31 - k);
        else
            m = q >> (k - 31);
        for (int i = 0; i < 32; i++)
        begin
            m = (m * m) >> 31;
            f <<= 1;
            if (m >= (64'd1 << 32))
            begin
                m >>= 1;
                f |= 1;
            end
        end
        return (longint'(PROB_BITS - k) << 32) - f;
    endfunction

    // Expected quantile and flag for one probability
    function automatic quant_t normal_quantile(logic [PROB_BITS-1:0] p);
        quant_t          res;
        longint unsigned q, lg, s2, t, num, den, ratio, mag, lim;
        longint          r;
        bit              lower, neg;
        if (p == 0)
        begin
            res.quantile = Q_NEG_ONE;
            res.invalid  = 1'b1;
            return res;
        end
        lower = p < (64'd1 << (PROB_BITS - 1));
        q  = lower ? 64'(p) : (64'd1 << PROB_BITS) - 64'(p);
        lg = minus_log2(q);
        s2 = ((lg >> 32) * LN2_FIX + (((lg & 64'hFFFF_FFFF) * LN2_FIX) >> 32)) << 1;
        t  = isqrt((s2 >> 8) << FB);
        num = ((C2 * t) >> FB) + C1;
        num = ((num * t) >> FB) + C0;
        den = ((D3 * t) >> FB) + D2;
        den = ((den * t) >> FB) + D1;
        den = ((den * t) >> FB) + (64'd1 << FB);
        ratio = (num << FB) / den;
        r   = longint'(t) - longint'(ratio);
        neg = r < 0;
        mag = neg ? longint'(-r) : r;
        if (lower)
            neg = !neg;
        if (SH >= 0)
            mag <<= SH_L;
        else
            mag >>= SH_R;
        lim = 64'd1 << (OUT_FRAC_BITS + 3);
        if (!neg && mag > lim - 1)
            mag = lim - 1;
        if (neg && mag > lim)
            mag = lim;
        res.quantile = neg ? OUT_W'(-mag) : OUT_W'(mag);
        res.invalid  = 1'b0;
        return res;
    endfunction

    // Random probability: mostly near the tails or uniform, with random shifts across all magnitudes
    function automatic logic [PROB_BITS-1:0] pick_prob();
        logic [PROB_BITS-1:0] p;
        case ($urandom_range(0, 5))
            0: p = PROB_BITS'($urandom_range(0, 255));
            1: p = ~PROB_BITS'($urandom_range(0, 255));
            2: p = PROB_BITS'($urandom) >> $urandom_range(0, PROB_BITS - 1);
            3: p = ~(PROB_BITS'($urandom) >> $urandom_range(0, PROB_BITS - 1));
            default: p = PROB_BITS'($urandom);
        endcase
        return p;
    endfunction

    // Drive one beat and hold it until accepted
    task automatic send_beat(logic [PROB_BITS-1:0] p);
        in_valid <= 1'b1;
        prob     <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_q.push_back(normal_quantile(p));
        @(negedge clk);
    endtask

    task automatic check_beat(quant_t want);
        if (quantile !== want.quantile)
        begin
            $error("quantile: expected %h, got %h", want.quantile, quantile);
            n_errors++;
        end
        if (invalid !== want.invalid)
        begin
            $error("invalid: expected %b, got %b", want.invalid, invalid);
            n_errors++;
        end
    endtask

    // Stimulus: directed table first, then random bursts with gaps
    initial
    begin
        row_t rows[$];
        row_t rw;
        int   sent;
        in_valid  = 1'b0;
        prob      = '0;
        rst_n     = 1'b0;
        n_errors  = 0;
        stim_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero probability is the invalid case, typed in
        rows.push_back('{prob: '0, fixed: 1'b1, want: '{Q_NEG_ONE, 1'b1}});
        rows.push_back('{prob: 32'h8000_0000, fixed: 1'b0, want: '0});  // exactly one half
        rows.push_back('{prob: 32'h7FFF_FFFF, fixed: 1'b0, want: '0});
        rows.push_back('{prob: 32'h8000_0001, fixed: 1'b0, want: '0});
        rows.push_back('{prob: 32'h0000_0001, fixed: 1'b0, want: '0});  // deepest tail
        rows.push_back('{prob: 32'hFFFF_FFFF, fixed: 1'b0, want: '0});
        rows.push_back('{prob: 32'h0000_0002, fixed: 1'b0, want: '0});
        rows.push_back('{prob: 32'hFFFF_FFFE, fixed: 1'b0, want: '0});
        rows.push_back('{prob: 32'h4000_0000, fixed: 1'b0, want: '0});
        rows.push_back('{prob: 32'hC000_0000, fixed: 1'b0, want: '0});
        rows.push_back('{prob: 32'h0000_FFFF, fixed: 1'b0, want: '0});
        rows.push_back('{prob: 32'h5555_5555, fixed: 1'b0, want: '0});
        rows.push_back('{prob: 32'hAAAA_AAAA, fixed: 1'b0, want: '0});
        rows.push_back('{prob: 32'h0CCC_CCCD, fixed: 1'b0, want: '0});
        rows.push_back('{prob: 32'hF333_3333, fixed: 1'b0, want: '0});
        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.fixed && normal_quantile(rw.prob) != rw.want)
            begin
                $error("table row %0d disagrees with predictor", i);
                n_errors++;
            end
            send_beat(rw.prob);
        end

        sent = 0;
        while (sent < N_RANDOM)
        begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && sent < N_RANDOM; b++)
            begin
                send_beat(pick_prob());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
        in_valid  <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: own stall pattern, plus one long hold-off to back-pressure the pipe
    initial
    begin
        int stall_cnt;
        out_ready  = 1'b0;
        long_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_stall && pending_q.size() > 20)
            begin
                long_stall = 1'b1;
                out_ready <= 1'b0;
                for (stall_cnt = 0; stall_cnt < 300; stall_cnt++)
                    @(negedge clk);
            end
            case ($urandom_range(0, 9))
                0, 1:    out_ready <= 1'b0;
                default: out_ready <= 1'b1;
            endcase
        end
    end

    // Scoreboard: compare each accepted output beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("output beat with no expectation pending");
                n_errors++;
            end
            else
                check_beat(pending_q.pop_front());
        end
    end

    // End of run: drain, settle, report
    initial
    begin
        wait (stim_done);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== inverse_normal_cdf_unit.f =====
rtl/core/inc_pkg.sv
rtl/core/inc_log2.sv
rtl/core/inc_sqrt.sv
rtl/core/inc_ratio.sv
rtl/core/inc_out.sv
rtl/core/inverse_normal_cdf_unit.sv
test/inverse_normal_cdf_unit_test.sv
